// ----- rtl/porc_pkg.sv -----
// ----------------------------------------------------------------------------
// porc_pkg
// Shared widths, constants and types of the pulse oximeter rate/SpO2 block.
// ----------------------------------------------------------------------------
package porc_pkg;

  localparam int WindowDepth  = 50;
  localparam int SmoothTaps   = 8;
  localparam int HistoryBeats = 10;

  localparam int SampleW   = 18;
  localparam int RateW     = 8;
  localparam int OxyW      = 7;
  localparam int SlopeW    = 16;
  localparam int SlopeThrW = 15;
  localparam int BeatW     = 8;
  localparam int TotalW    = BeatW + $clog2(HistoryBeats);
  localparam int SumW      = SampleW + $clog2(SmoothTaps) + 1;
  localparam int ScanW     = $clog2(WindowDepth + 1);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 18;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SLOPE    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MINBEAT  = 2'd2;

  localparam logic [SampleW-1:0]   PresenceRst = 18'd40000;
  localparam logic [SlopeThrW-1:0] SlopeRst    = 15'd50;
  localparam logic [BeatW-1:0]     MinBeatRst  = 8'd12;

  localparam int ProdW = 2 * SampleW;
  localparam int RemW  = ProdW + 1;
  localparam int QW    = 16;

  localparam logic [QW-1:0]  Q16Low  = 16'd23593;
  localparam logic [QW-1:0]  Q16Mid  = 16'd43254;
  localparam logic [23:0]    Seg1Off = 24'd7012352;
  localparam logic [23:0]    Seg2Off = 24'd8496087;

  localparam int RateQW = 15;
  localparam logic [RateQW-1:0] RateNum = 15'd30000;

  typedef struct packed {
    logic [SampleW-1:0] rmin;
    logic [SampleW-1:0] rmax;
    logic [SampleW-1:0] imin;
    logic [SampleW-1:0] imax;
  } span_t;

  typedef struct packed {
    logic          done;
    logic          ok;
    logic [QW-1:0] q;
  } ratio_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MUL, ST_START, ST_DIV, ST_OUT
  } state_e;

endpackage

// ----- rtl/porc_cell.sv -----
// ----------------------------------------------------------------------------
// porc_cell
// One window entry (red and ir) with a registered min/max stage of the span chain.
// ----------------------------------------------------------------------------
module porc_cell import porc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic [SampleW-1:0] red_i,
  input  logic [SampleW-1:0] ir_i,
  input  span_t              span_i,
  output logic [SampleW-1:0] red_o,
  output logic [SampleW-1:0] ir_o,
  output span_t              span_o
);

  logic [SampleW-1:0] red_q, red_d, ir_q, ir_d;
  span_t span_q, span_d;

  always_comb begin
    red_d = shift_i ? red_i : red_q;
    ir_d  = shift_i ? ir_i  : ir_q;
    span_d.rmin = (red_q < span_i.rmin) ? red_q : span_i.rmin;
    span_d.rmax = (red_q > span_i.rmax) ? red_q : span_i.rmax;
    span_d.imin = (ir_q  < span_i.imin) ? ir_q  : span_i.imin;
    span_d.imax = (ir_q  > span_i.imax) ? ir_q  : span_i.imax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q <= '0;
      ir_q  <= '0;
    end else begin
      red_q <= red_d;
      ir_q  <= ir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q <= span_d;
  end

  assign red_o  = red_q;
  assign ir_o   = ir_q;
  assign span_o = span_q;

endmodule

// ----- rtl/porc_div.sv -----
// ----------------------------------------------------------------------------
// porc_div
// Serial restoring divider for the Q16 ratio of ratios, one bit per cycle.
// ----------------------------------------------------------------------------
module porc_div import porc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] num_i,
  input  logic [ProdW-1:0] den_i,
  output ratio_t           res_o
);

  logic             busy_q, busy_d, done_q, done_d, ok_q, ok_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [RemW-1:0]  rem_q, rem_d, rem_sh;
  logic [ProdW-1:0] den_q, den_d;
  logic [QW-1:0]    q_q, q_d;
  logic             ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ok_d   = ok_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    q_d    = q_q;
    rem_sh = {rem_q[RemW-2:0], 1'b0};
    ge     = rem_sh >= {1'b0, den_q};
    if (start_i) begin
      den_d = den_i;
      cnt_d = '0;
      q_d   = '0;
      rem_d = {1'b0, num_i};
      if (den_i == '0 || num_i >= den_i) begin
        done_d = 1'b1;
        ok_d   = 1'b0;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, den_q} : rem_sh;
      q_d   = {q_q[QW-2:0], ge};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        ok_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ok_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ok_q   <= ok_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    q_q   <= q_d;
  end

  assign res_o.done = done_q;
  assign res_o.ok   = ok_q;
  assign res_o.q    = q_q;

endmodule

// ----- rtl/pulse_oximeter_rate_spo2.sv -----
// ----------------------------------------------------------------------------
// pulse_oximeter_rate_spo2
// Heart rate and SpO2 estimate from red/infrared photodiode samples.
//
//   channel | handshake            | payload
//   in      | in_valid_i/in_stall_o | red_sample_i, ir_sample_i
//   out     | out_valid_o/out_stall_i | heart_rate_o .. beat_detected_o
//   cfg     | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// A word with finger passes through SCAN (the min/max chain), MUL (the two
// products), START (divider start), DIV (the ratio divider) and OUT (load
// the output register); the divider ends at once when R >= 1 or a divisor
// is zero. A word without finger goes straight from IDLE to OUT.
// One word is in flight; the next is taken once the result sits in the
// output register. Reset clears the windows and the control state at once.
// ----------------------------------------------------------------------------
module pulse_oximeter_rate_spo2 import porc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SampleW-1:0]    red_sample_i,
  input  logic [SampleW-1:0]    ir_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [RateW-1:0]      heart_rate_o,
  output logic [OxyW-1:0]       oxygen_level_o,
  output logic signed [SlopeW-1:0] slope_o,
  output logic                  finger_present_o,
  output logic                  beat_detected_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  state_e state_q, state_d;

  logic [SampleW-1:0]   pres_thr_q;
  logic [SlopeThrW-1:0] slope_thr_q;
  logic [BeatW-1:0]     min_beat_q;

  logic [SampleW-1:0] red_tap [WindowDepth];
  logic [SampleW-1:0] ir_tap  [WindowDepth];
  span_t              span    [WindowDepth];
  span_t              head_span;

  logic [BeatW-1:0]   hist_q [HistoryBeats];
  logic [TotalW-1:0]  total_q, total_d;
  logic [BeatW-1:0]   beat_cnt_q, beat_cnt_d;
  logic [SampleW-1:0] last_q, last_d;
  logic [RateW-1:0]   rate_q, rate_d;
  logic [OxyW-1:0]    oxy_q, oxy_d;
  logic [SlopeW-1:0]  slope_q, slope_d;
  logic               fp_q, fp_d, beat_q, beat_d;

  logic               rbusy_q, rbusy_d;
  logic [3:0]         rcnt_q, rcnt_d;
  logic [TotalW-1:0]  rrem_q, rrem_d;
  logic [RateQW-1:0]  rquo_q, rquo_d;
  logic [TotalW:0]    rsh;
  logic               rge;
  logic [RateQW-1:0]  rfinal;

  logic [ScanW-1:0]   scan_q, scan_d;
  logic [ProdW-1:0]   pnum_q, pden_q;
  ratio_t             ratio;

  logic               out_valid_q, out_valid_d, load;
  logic [RateW-1:0]   hr_q;
  logic [OxyW-1:0]    ox_q;
  logic [SlopeW-1:0]  sl_q;
  logic               fpo_q, bto_q;

  logic               accept, finger, shift;
  logic [SumW-1:0]    smooth_sum;
  logic [SampleW-1:0] smoothed;
  logic [SlopeW-1:0]  slope_new;
  logic               beat_new;
  logic [SampleW-1:0] acr, aci;
  logic [SampleW:0]   dcr_s, dci_s;
  logic [23:0]        oxy_seg;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign finger     = ir_sample_i >= pres_thr_q;
  assign shift      = accept && finger;

  assign head_span.rmin = red_tap[0];
  assign head_span.rmax = red_tap[0];
  assign head_span.imin = ir_tap[0];
  assign head_span.imax = ir_tap[0];

  for (genvar k = 0; k < WindowDepth; k++) begin : g_cell
    if (k == 0) begin : g_head
      porc_cell u_cell (
        .clk_i, .rst_ni, .shift_i(shift),
        .red_i(red_sample_i), .ir_i(ir_sample_i), .span_i(head_span),
        .red_o(red_tap[k]), .ir_o(ir_tap[k]), .span_o(span[k])
      );
    end else begin : g_body
      porc_cell u_cell (
        .clk_i, .rst_ni, .shift_i(shift),
        .red_i(red_tap[k-1]), .ir_i(ir_tap[k-1]), .span_i(span[k-1]),
        .red_o(red_tap[k]), .ir_o(ir_tap[k]), .span_o(span[k])
      );
    end
  end

  // new sample counts twice, plus window entries 0 .. SmoothTaps-3
  always_comb begin
    smooth_sum = {{(SumW-SampleW){1'b0}}, ir_sample_i} + {{(SumW-SampleW){1'b0}}, ir_sample_i};
    for (int k = 0; k < SmoothTaps - 2; k++) begin
      smooth_sum = smooth_sum + {{(SumW-SampleW){1'b0}}, ir_tap[k]};
    end
  end
  assign smoothed  = SampleW'(smooth_sum / SumW'(SmoothTaps));
  assign slope_new = last_q[SlopeW-1:0] - smoothed[SlopeW-1:0];
  assign beat_new  = ($signed(slope_new) > $signed({1'b0, slope_thr_q}))
                     && (beat_cnt_q > min_beat_q);

  assign acr   = span[WindowDepth-1].rmax - span[WindowDepth-1].rmin;
  assign aci   = span[WindowDepth-1].imax - span[WindowDepth-1].imin;
  assign dcr_s = ({1'b0, span[WindowDepth-1].rmax} + {1'b0, span[WindowDepth-1].rmin}) >> 1;
  assign dci_s = ({1'b0, span[WindowDepth-1].imax} + {1'b0, span[WindowDepth-1].imin}) >> 1;

  porc_div u_div (
    .clk_i, .rst_ni,
    .start_i(state_q == ST_START),
    .num_i(pnum_q), .den_i(pden_q), .res_o(ratio)
  );

  assign rsh    = {rrem_q, rquo_q[RateQW-1]};
  assign rge    = rsh >= {1'b0, total_q};
  assign rfinal = {rquo_q[RateQW-2:0], rge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = finger ? ST_SCAN : ST_OUT;
      ST_SCAN:  if (scan_q == ScanW'(WindowDepth)) state_d = ST_MUL;
      ST_MUL:   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (ratio.done) state_d = ST_OUT;
      ST_OUT:   if (load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    total_d    = total_q;
    beat_cnt_d = beat_cnt_q;
    last_d     = last_q;
    rate_d     = rate_q;
    oxy_d      = oxy_q;
    slope_d    = slope_q;
    fp_d       = fp_q;
    beat_d     = beat_q;
    rbusy_d    = rbusy_q;
    rcnt_d     = rcnt_q;
    rrem_d     = rrem_q;
    rquo_d     = rquo_q;
    scan_d     = (state_q == ST_SCAN) ? scan_q + ScanW'(1) : '0;
    oxy_seg    = '0;
    if (accept) begin
      fp_d   = finger;
      beat_d = 1'b0;
      if (!finger) begin
        rate_d  = '0;
        oxy_d   = '0;
        slope_d = '0;
      end else begin
        slope_d    = slope_new;
        last_d     = smoothed;
        beat_cnt_d = beat_cnt_q + BeatW'(1);
        if (beat_new) begin
          beat_d     = 1'b1;
          beat_cnt_d = BeatW'(1);
          total_d    = total_q - TotalW'(hist_q[HistoryBeats-1]) + TotalW'(beat_cnt_q);
          rbusy_d    = 1'b1;
          rcnt_d     = '0;
          rrem_d     = '0;
          rquo_d     = RateNum;
        end
      end
    end
    if (rbusy_q) begin
      rrem_d = rge ? TotalW'(rsh - {1'b0, total_q}) : TotalW'(rsh);
      rquo_d = rfinal;
      rcnt_d = rcnt_q + 4'd1;
      if (rcnt_q == 4'(RateQW - 1)) begin
        rbusy_d = 1'b0;
        if (total_q != '0) begin
          rate_d = (rfinal > RateQW'(255)) ? RateW'(255) : rfinal[RateW-1:0];
        end
      end
    end
    if (state_q == ST_DIV && ratio.done && ratio.ok) begin
      if (ratio.q >= Q16Low && ratio.q < Q16Mid) begin
        oxy_seg = Seg1Off - 24'(ratio.q) * 24'd20;
        oxy_d   = oxy_seg[16 +: OxyW];
      end else if (ratio.q >= Q16Mid) begin
        oxy_seg = Seg2Off - 24'(ratio.q) * 24'd54;
        oxy_d   = oxy_seg[16 +: OxyW];
      end
    end
  end

  assign load        = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pres_thr_q  <= PresenceRst;
      slope_thr_q <= SlopeRst;
      min_beat_q  <= MinBeatRst;
      for (int k = 0; k < HistoryBeats; k++) hist_q[k] <= '0;
      total_q     <= '0;
      beat_cnt_q  <= '0;
      last_q      <= '0;
      rate_q      <= '0;
      oxy_q       <= '0;
      slope_q     <= '0;
      fp_q        <= 1'b0;
      beat_q      <= 1'b0;
      rbusy_q     <= 1'b0;
      rcnt_q      <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PRESENCE: pres_thr_q  <= cfg_data_i[SampleW-1:0];
          CFG_SLOPE:    slope_thr_q <= cfg_data_i[SlopeThrW-1:0];
          CFG_MINBEAT:  min_beat_q  <= cfg_data_i[BeatW-1:0];
          default: ;
        endcase
      end
      if (shift && beat_new) begin
        hist_q[0] <= beat_cnt_q;
        for (int k = 1; k < HistoryBeats; k++) hist_q[k] <= hist_q[k-1];
      end
      total_q     <= total_d;
      beat_cnt_q  <= beat_cnt_d;
      last_q      <= last_d;
      rate_q      <= rate_d;
      oxy_q       <= oxy_d;
      slope_q     <= slope_d;
      fp_q        <= fp_d;
      beat_q      <= beat_d;
      rbusy_q     <= rbusy_d;
      rcnt_q      <= rcnt_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rrem_q <= rrem_d;
    rquo_q <= rquo_d;
    if (state_q == ST_MUL) begin
      pnum_q <= ProdW'(acr) * ProdW'(dci_s[SampleW-1:0]);
      pden_q <= ProdW'(dcr_s[SampleW-1:0]) * ProdW'(aci);
    end
    if (load) begin
      hr_q  <= rate_q;
      ox_q  <= oxy_q;
      sl_q  <= slope_q;
      fpo_q <= fp_q;
      bto_q <= beat_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign heart_rate_o     = hr_q;
  assign oxygen_level_o   = ox_q;
  assign slope_o          = $signed(sl_q);
  assign finger_present_o = fpo_q;
  assign beat_detected_o  = bto_q;

endmodule
